### rtl/core/cabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabs_pkg
// shared widths and constants for the caustic alpha bilinear sampler
// ----------------------------------------------------------------------------
package cabs_pkg;

    localparam int TEX_AW   = 16;
    localparam int TEXEL_W  = 8;
    localparam int BANKS    = 4;
    localparam int BANK_AW  = TEX_AW - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int COORD_W  = 24;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [31:0] RECIP_DIV5 = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_DIV3 = 32'hAAAA_AAAB;
    localparam logic [7:0]  RECIP_DIV3_NARROW = 8'd171;

    localparam logic [7:0] RAMP_HIGH = 8'd160;
    localparam logic [7:0] RAMP_LOW  = 8'd128;
    localparam logic [7:0] RAMP_TOP  = 8'd255;

endpackage

### rtl/core/cabs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabs_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module cabs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/caustic_alpha_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caustic_alpha_bilinear_sampler_top
// 256x256 texture in four row/column parity banks, two bilinear samples
// per pixel, averaged and shaped into an alpha value
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                         | tuser
//  s_      | in  | texel_address, texel_value, pixel_x, pixel_y,  | kind
//          |     | frame_count (53 bits, padded to 56)            |
//  m_      | out | pixel_alpha (7 bits, padded to 8)              | -
//
//  a pixel item occupies the bank issue stage once per sample, sample 1 first;
//  a load item once. stages: input, divide, issue, bank read, sample, output
//  reset clears control state only; the texture is undefined until loaded
//  a stalled result freezes the issue stage and everything behind it
// ----------------------------------------------------------------------------
module caustic_alpha_bilinear_sampler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // texel_address, texel_value, pixel_x, pixel_y, frame_count
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // pixel_alpha
);

    localparam int COORD_W = cabs_pkg::COORD_W;
    localparam logic [63:0] RECIP_DIV5_64 = {32'd0, cabs_pkg::RECIP_DIV5};
    localparam logic [63:0] RECIP_DIV3_64 = {32'd0, cabs_pkg::RECIP_DIV3};

    logic stall;
    logic iss_ready, div_ready, in_ready;

    // input stage
    logic        in_valid_reg, in_kind_reg;
    logic [15:0] in_addr_reg, in_fc_reg;
    logic [7:0]  in_val_reg;
    logic [6:0]  in_x_reg;
    logic [5:0]  in_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_val_reg  <= s_tdata[23:16];
            in_x_reg    <= s_tdata[30:24];
            in_y_reg    <= s_tdata[36:31];
            in_fc_reg   <= s_tdata[52:37];
        end
    end

    assign s_tready = in_ready;

    // division by ten and six through reciprocals
    logic [15:0] fc1;
    logic [16:0] mag0, mag1;
    logic [63:0] prod10, prod6;

    assign fc1    = in_fc_reg + 16'd1;
    assign mag0   = in_fc_reg[15] ? 17'(17'd0 - {1'b1, in_fc_reg}) : {1'b0, in_fc_reg};
    assign mag1   = fc1[15] ? 17'(17'd0 - {1'b1, fc1}) : {1'b0, fc1};
    assign prod10 = {mag0, 15'd0} * RECIP_DIV5_64;
    assign prod6  = {mag1, 15'd0} * RECIP_DIV3_64;

    logic        div_valid_reg, div_kind_reg, div_neg0_reg, div_neg1_reg;
    logic [15:0] div_addr_reg, div_fc_reg;
    logic [7:0]  div_val_reg;
    logic [6:0]  div_x_reg;
    logic [5:0]  div_y_reg;
    logic [23:0] div_q10_reg;
    logic [23:0] div_q6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= 1'b0;
        end else if (div_ready) begin
            div_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready && in_valid_reg) begin
            div_kind_reg <= in_kind_reg;
            div_addr_reg <= in_addr_reg;
            div_val_reg  <= in_val_reg;
            div_x_reg    <= in_x_reg;
            div_y_reg    <= in_y_reg;
            div_fc_reg   <= in_fc_reg;
            div_neg0_reg <= in_fc_reg[15];
            div_neg1_reg <= fc1[15];
            div_q10_reg  <= prod10[57:34];
            div_q6_reg   <= prod6[56:33];
        end
    end

    // coordinate forming, low 24 bits are all that matter
    logic [COORD_W-1:0] d10, d6, p0d8, tu, u0_c, v0_c, u1_c, v1_c;

    assign d10  = div_neg0_reg ? COORD_W'(24'd0 - div_q10_reg) : div_q10_reg;
    assign d6   = div_neg1_reg ? COORD_W'(24'd0 - div_q6_reg) : div_q6_reg;
    assign p0d8 = {div_fc_reg[10:0], 13'd0};
    assign tu   = {div_x_reg, 17'd0};
    assign u1_c = COORD_W'(tu - d6);
    assign v1_c = COORD_W'({COORD_W'(9'd256 - {3'd0, div_y_reg}), 17'd0} + p0d8);
    assign u0_c = COORD_W'(tu + d10);
    assign v0_c = {1'b0, div_y_reg, 17'd0};

    // bank issue stage
    logic               iss_valid_reg, iss_kind_reg, iss_phase_reg;
    logic [15:0]        iss_addr_reg;
    logic [7:0]         iss_val_reg;
    logic [COORD_W-1:0] iss_u0_reg, iss_v0_reg, iss_u1_reg, iss_v1_reg;
    logic               iss_done;

    assign iss_done  = (iss_kind_reg == cabs_pkg::KIND_LOAD) || iss_phase_reg;
    assign iss_ready = !iss_valid_reg || (iss_done && !stall);
    assign div_ready = !div_valid_reg || iss_ready;
    assign in_ready  = !in_valid_reg || div_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_valid_reg <= 1'b0;
            iss_phase_reg <= 1'b0;
        end else if (iss_ready) begin
            iss_valid_reg <= div_valid_reg;
            iss_phase_reg <= 1'b0;
        end else if (iss_valid_reg && !stall) begin
            iss_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (iss_ready && div_valid_reg) begin
            iss_kind_reg <= div_kind_reg;
            iss_addr_reg <= div_addr_reg;
            iss_val_reg  <= div_val_reg;
            iss_u0_reg   <= u0_c;
            iss_v0_reg   <= v0_c;
            iss_u1_reg   <= u1_c;
            iss_v1_reg   <= v1_c;
        end
    end

    // sample 1 first, then sample 0
    logic [COORD_W-1:0] cu, cv;
    logic [7:0]  iu0, iu1, iv0, iv1;
    logic [15:0] fu1, fu0, fv1, fv0;
    logic [31:0] w_10, w_11, w_00, w_01;
    logic        is_load;

    assign cu  = iss_phase_reg ? iss_u0_reg : iss_u1_reg;
    assign cv  = iss_phase_reg ? iss_v0_reg : iss_v1_reg;
    assign iu0 = cu[23:16];
    assign iv0 = cv[23:16];
    assign iu1 = 8'(iu0 + 8'd1);
    assign iv1 = 8'(iv0 + 8'd1);
    assign fu1 = {cu[15:1], 1'b1};
    assign fv1 = {cv[15:1], 1'b1};
    assign fu0 = 16'(16'd0 - fu1);
    assign fv0 = 16'(16'd0 - fv1);
    assign w_10 = fu0 * fv1;
    assign w_11 = fu1 * fv1;
    assign w_00 = fu0 * fv0;
    assign w_01 = fu1 * fv0;
    assign is_load = iss_kind_reg == cabs_pkg::KIND_LOAD;

    logic [7:0] bank_rdata [cabs_pkg::BANKS];

    for (genvar b = 0; b < cabs_pkg::BANKS; b++) begin : g_bank
        logic [7:0] row, col;
        logic [cabs_pkg::BANK_AW-1:0] baddr;
        logic bwe;

        assign row   = (iv0[0] == 1'(b >> 1)) ? iv0 : iv1;
        assign col   = (iu0[0] == 1'(b)) ? iu0 : iu1;
        assign baddr = is_load ? {iss_addr_reg[15:9], iss_addr_reg[7:1]}
                               : {row[7:1], col[7:1]};
        assign bwe   = iss_valid_reg && is_load
                       && (iss_addr_reg[8] == 1'(b >> 1)) && (iss_addr_reg[0] == 1'(b));

        cabs_ram #(
            .WIDTH (cabs_pkg::TEXEL_W),
            .DEPTH (cabs_pkg::BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .en    (!stall),
            .we    (bwe),
            .addr  (baddr),
            .wdata (iss_val_reg),
            .rdata (bank_rdata[b])
        );
    end

    // read data stage
    logic        rd_valid_reg, rd_phase_reg, rd_iu0p_reg, rd_iv0p_reg;
    logic [15:0] rd_w10_reg, rd_w11_reg, rd_w00_reg, rd_w01_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (!stall) begin
            rd_valid_reg <= iss_valid_reg && !is_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            rd_phase_reg <= iss_phase_reg;
            rd_iu0p_reg  <= iu0[0];
            rd_iv0p_reg  <= iv0[0];
            rd_w10_reg   <= w_10[31:16];
            rd_w11_reg   <= w_11[31:16];
            rd_w00_reg   <= w_00[31:16];
            rd_w01_reg   <= w_01[31:16];
        end
    end

    logic [7:0]  t10, t11, t00, t01;
    logic [23:0] m10, m11, m00, m01;
    logic [9:0]  tsum;

    assign t10  = bank_rdata[{~rd_iv0p_reg, rd_iu0p_reg}];
    assign t11  = bank_rdata[{~rd_iv0p_reg, ~rd_iu0p_reg}];
    assign t00  = bank_rdata[{rd_iv0p_reg, rd_iu0p_reg}];
    assign t01  = bank_rdata[{rd_iv0p_reg, ~rd_iu0p_reg}];
    assign m10  = rd_w10_reg * t10;
    assign m11  = rd_w11_reg * t11;
    assign m00  = rd_w00_reg * t00;
    assign m01  = rd_w01_reg * t01;
    assign tsum = {2'd0, m10[23:16]} + {2'd0, m11[23:16]}
                + {2'd0, m00[23:16]} + {2'd0, m01[23:16]};

    // sample stage
    logic       smp_valid_reg, smp_phase_reg;
    logic [7:0] smp_reg, s1_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_valid_reg <= 1'b0;
        end else if (!stall) begin
            smp_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            smp_reg       <= tsum[7:0];
            smp_phase_reg <= rd_phase_reg;
            if (smp_valid_reg && !smp_phase_reg) begin
                s1_hold_reg <= smp_reg;
            end
        end
    end

    // average, ramp and divide by three
    logic [8:0]  avg2;
    logic [7:0]  avg, ramp, over;
    logic [15:0] div3;

    assign avg2 = {1'b0, smp_reg} + {1'b0, s1_hold_reg};
    assign avg  = avg2[8:1];
    assign over = 8'(avg - cabs_pkg::RAMP_HIGH);

    always_comb begin
        priority if (avg >= cabs_pkg::RAMP_HIGH) begin
            ramp = 8'(cabs_pkg::RAMP_TOP - {over[6:0], 1'b0});
        end else if (avg >= cabs_pkg::RAMP_LOW) begin
            ramp = 8'({avg[6:0], 2'b00} + {2'b00, avg[6:0]});
        end else begin
            ramp = 8'd0;
        end
    end

    assign div3 = ramp * cabs_pkg::RECIP_DIV3_NARROW;

    logic       out_valid_reg;
    logic [6:0] out_alpha_reg;

    assign stall = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            out_valid_reg <= smp_valid_reg && smp_phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            out_alpha_reg <= div3[15:9];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_alpha_reg};

endmodule

### dv/tb_caustic_alpha_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_caustic_alpha_bilinear_sampler_top
// self-checking bench: runs a directed table of pixel items twice (zero
// texture, then random texture), loading only the texels each pixel reads,
// then random mixes of loads and pixels under several idle and stall
// settings, one long receiver hold-off included; results are checked
// against a predictor
// ----------------------------------------------------------------------------
module tb_caustic_alpha_bilinear_sampler_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;  // texel_address, texel_value, pixel_x, pixel_y, frame_count
    logic        s_tuser;  // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;  // pixel_alpha

    caustic_alpha_bilinear_sampler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [6:0]  px;
        logic [5:0]  py;
        logic [15:0] fc;
    } pix_item_t;

    logic [7:0]  texture_mirror [65536];
    bit          loaded [65536];
    logic [15:0] loaded_list [$];
    pix_item_t   pool [$];
    logic [6:0]  alpha_q [$];
    int          fail_cnt = 0;
    int          sent_cnt;
    int          idle_pct;
    int          stall_pct;
    int          hold_reqs;
    int          holds_done = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    bit          running;
    bit          use_typed;
    logic [6:0]  typed_alpha;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // bilinear sample with wrapped addressing
    function automatic int unsigned sample_at(logic [31:0] u, logic [31:0] v);
        longint unsigned fu1, fv1, fu0, fv0, w, sum;
        logic [7:0] iu0, iu1, iv0, iv1;
        fu1 = longint'(u[15:1]) * 2 + 1;
        fv1 = longint'(v[15:1]) * 2 + 1;
        fu0 = 65536 - fu1;
        fv0 = 65536 - fv1;
        iu0 = u[23:16];
        iu1 = iu0 + 8'd1;
        iv0 = v[23:16];
        iv1 = iv0 + 8'd1;
        sum = 0;
        w = (fu0 * fv1) >> 16; sum += (w * texture_mirror[{iv1, iu0}]) >> 16;
        w = (fu1 * fv1) >> 16; sum += (w * texture_mirror[{iv1, iu1}]) >> 16;
        w = (fu0 * fv0) >> 16; sum += (w * texture_mirror[{iv0, iu0}]) >> 16;
        w = (fu1 * fv0) >> 16; sum += (w * texture_mirror[{iv0, iu1}]) >> 16;
        return int'(sum & 255);
    endfunction

    function automatic void pixel_coords(input logic [6:0] px, input logic [5:0] py,
                                         input logic [15:0] fc,
                                         output logic [31:0] u1, output logic [31:0] v1,
                                         output logic [31:0] u0, output logic [31:0] v0);
        logic [31:0] tu, p0, p1;
        logic [15:0] fc_next;
        int q1, q8, q10;
        fc_next = fc + 16'd1;
        tu  = 32'(px) << 17;
        p0  = {fc, 16'h0};
        p1  = {fc_next, 16'h0};
        q1  = $signed(p1) / 6;
        q8  = $signed(p0) / 8;
        q10 = $signed(p0) / 10;
        u1  = tu - 32'(q1);
        v1  = ((32'd256 - 32'(py)) << 17) + 32'(q8);
        u0  = tu + 32'(q10);
        v0  = 32'(py) << 17;
    endfunction

    function automatic logic [6:0] caustic_alpha(logic [6:0] px, logic [5:0] py,
                                                 logic [15:0] fc);
        logic [31:0] u1, v1, u0, v0;
        int unsigned s0, s1, avg, ramp;
        pixel_coords(px, py, fc, u1, v1, u0, v0);
        s1  = sample_at(u1, v1);
        s0  = sample_at(u0, v0);
        avg = (s0 + s1) / 2;
        if (avg >= 160) begin
            ramp = 255 - 2 * (avg - 160);
        end else if (avg >= 128) begin
            ramp = 5 * (avg - 128);
        end else begin
            ramp = 0;
        end
        return 7'(ramp / 3);
    endfunction

    task automatic send(pix_item_t it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b0, it.fc, it.py, it.px, it.value, it.addr};
        do @(posedge aclk); while (!s_tready);
        if (it.kind == cabs_pkg::KIND_LOAD) begin
            texture_mirror[it.addr] = it.value;
        end else begin
            alpha_q.push_back(use_typed ? typed_alpha : caustic_alpha(it.px, it.py, it.fc));
        end
        sent_cnt++;
        @(negedge aclk);
    endtask

    function automatic pix_item_t rand_item(logic kind);
        pix_item_t it;
        it.kind  = kind;
        it.addr  = 16'($urandom);
        it.value = 8'($urandom);
        it.px    = 7'($urandom);
        it.py    = 6'($urandom);
        it.fc    = 16'($urandom);
        case ($urandom_range(7))
            0: it.fc = 16'hFFFF;
            1: it.fc = 16'h0000;
            2: it.fc = 16'h8000;
            default: ;
        endcase
        return it;
    endfunction

    // load the texels a pixel reads that have not been loaded yet
    task automatic load_needed(pix_item_t it, bit zero);
        logic [31:0] c [4];
        logic [15:0] a;
        pix_item_t   ld;
        pixel_coords(it.px, it.py, it.fc, c[0], c[1], c[2], c[3]);
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 4; k++) begin
                a = {8'(c[2*s+1][23:16] + 8'(k >> 1)), 8'(c[2*s][23:16] + 8'(k & 1))};
                if (!loaded[a]) begin
                    ld = rand_item(cabs_pkg::KIND_LOAD);
                    ld.addr = a;
                    if (zero) ld.value = 8'd0;
                    loaded[a] = 1'b1;
                    loaded_list.push_back(a);
                    send(ld);
                end
            end
        end
    endtask

    task automatic send_pixel(pix_item_t it, bit zero);
        load_needed(it, zero);
        send(it);
    endtask

    task automatic clear_loaded();
        foreach (loaded[i]) loaded[i] = 1'b0;
        loaded_list.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (alpha_q.size() == 0);
        repeat (12) @(negedge aclk);
    endtask

    // directed pixel rows: extremes of position and frame count
    pix_item_t dir_rows [10];

    task automatic run_table(bit zero);
        foreach (dir_rows[i]) send_pixel(dir_rows[i], zero);
    endtask

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < hold_reqs) begin
            m_tready   <= 1'b0;
            hold_left  <= 400;
            holds_done <= holds_done + 1;
        end else begin
            m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (alpha_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected pixel alpha %0d", m_tdata);
            end else begin
                if (m_tdata !== {1'b0, alpha_q[0]}) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("alpha mismatch: expected %0d, got %0d", alpha_q[0], m_tdata);
                end
                void'(alpha_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!running || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 3000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        pix_item_t it;
        int        phase_start;
        int        r;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = cabs_pkg::KIND_LOAD;
        aresetn      = 1'b0;
        sent_cnt     = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_reqs    = 0;
        running      = 1'b0;
        use_typed    = 1'b0;
        typed_alpha  = '0;
        for (int i = 0; i < 10; i++) dir_rows[i] = rand_item(cabs_pkg::KIND_PIXEL);
        dir_rows[0].px = 7'd0;   dir_rows[0].py = 6'd0;  dir_rows[0].fc = 16'h0000;
        dir_rows[1].px = 7'd127; dir_rows[1].py = 6'd63; dir_rows[1].fc = 16'hFFFF;
        dir_rows[2].px = 7'd0;   dir_rows[2].py = 6'd63; dir_rows[2].fc = 16'h8000;
        dir_rows[3].px = 7'd127; dir_rows[3].py = 6'd0;  dir_rows[3].fc = 16'h7FFF;
        dir_rows[4].fc = 16'hFFFF;
        dir_rows[5].fc = 16'hFFFE;
        dir_rows[6].fc = 16'h0001;
        dir_rows[7].addr = 16'hFFFF; dir_rows[7].value = 8'hFF;
        dir_rows[8].addr = 16'h0000; dir_rows[8].value = 8'h00;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        running  = 1'b1;
        @(negedge aclk);

        // zero texture: every pixel gives alpha zero
        use_typed = 1'b1;
        run_table(1'b1);
        drain();
        use_typed = 1'b0;

        clear_loaded();
        run_table(1'b0);
        drain();
        foreach (dir_rows[i]) pool.push_back(dir_rows[i]);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                3: begin idle_pct = 34; stall_pct = 34; end
                default: begin idle_pct = 0; stall_pct = 10; hold_reqs = 1; end
            endcase
            phase_start = sent_cnt;
            while (sent_cnt - phase_start < 64) begin
                r = $urandom_range(7);
                if (r < 2) begin
                    it = rand_item(cabs_pkg::KIND_LOAD);
                    it.addr = loaded_list[$urandom_range(loaded_list.size() - 1)];
                    send(it);
                end else if (r == 2) begin
                    it = rand_item(cabs_pkg::KIND_PIXEL);
                    send_pixel(it, 1'b0);
                    pool.push_back(it);
                end else begin
                    it = pool[$urandom_range(pool.size() - 1)];
                    send(it);
                end
            end
            drain();
        end

        running = 1'b0;
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
